@@ hdl/sparse_set_slot_allocator_macros.svh @@
// Assertion macros shared by the slot allocator RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef SPARSE_SET_SLOT_ALLOCATOR_MACROS_SVH
`define SPARSE_SET_SLOT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SSSA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("slot allocator assertion failed");

// Next-cycle implication, disabled while reset is high.
`define SSSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slot allocator assertion failed");

`endif

@@ hdl/sssa_pkg.sv @@
// Package of the sparse set slot allocator: field widths, operation and status codes.
// Depends on nothing; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package sssa_pkg;

   localparam int MODE_W   = 2;
   localparam int INDEX_W  = 12;
   localparam int SLOT_W   = 12;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 13;

   localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_GET    = 2'd2;
   localparam logic [MODE_W-1:0] MODE_CHECK  = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_LIVE = 2'd2;

   typedef logic [MODE_W-1:0]   mode_type;
   typedef logic [INDEX_W-1:0]  index_type;
   typedef logic [SLOT_W-1:0]   slot_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [COUNT_W-1:0]  count_type;

endpackage

@@ hdl/sssa_channels.sv @@
// Valid/ready channel interfaces for the request and response sides of the allocator.
// Depends on sssa_pkg for the field types.
`timescale 1ns / 1ps

interface sssa_req_if;
   logic                 valid;
   logic                 ready;
   sssa_pkg::mode_type   mode;
   sssa_pkg::index_type  index;

   modport source (output valid, output mode, output index, input ready);
   modport sink (input valid, input mode, input index, output ready);
endinterface

interface sssa_rsp_if;
   logic                 valid;
   logic                 ready;
   sssa_pkg::slot_type   slot;
   sssa_pkg::status_type status;
   sssa_pkg::count_type  live_count;

   modport source (output valid, output slot, output status, output live_count, input ready);
   modport sink (input valid, input slot, input status, input live_count, output ready);
endinterface

@@ hdl/sssa_ram.sv @@
// Generic single-write, single-read synchronous RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module sssa_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // The read data holds while rd_en is low.
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/sparse_set_slot_allocator.sv @@
// Sparse set slot allocator: add hands out a slot (most recently freed first, else the next
// never-used one), remove frees a live slot, get returns the slot at a dense position and
// check tests whether a slot is live. One transfer on req_ch yields exactly one transfer on
// rsp_ch. Operations run one at a time. The first memory reads are launched at the edge of
// the request transfer. Add and get load the response register from ST_READ, and remove
// and check from ST_LINK, which follows ST_READ for the dependent read of the dense list
// at the position just read from the position memory; either state holds until the
// response register is free. A new request is taken in the cycle after the response
// register is loaded. The block takes a new request while a response still waits on
// rsp_ch; that next operation then holds in its final cycle until the response register
// drains. All state sits in three memories of CAPACITY entries with a registered read
// port (slot position, dense list, free stack) plus three counters. No clearing pass
// follows reset: the counters bound every read to entries already written, so the block
// is ready in the first cycle after reset.
// Depends on sssa_pkg, sssa_channels, sssa_ram and the assertion macros header.
`timescale 1ns / 1ps
`include "sparse_set_slot_allocator_macros.svh"

module sparse_set_slot_allocator #(
   parameter int CAPACITY = 4096
) (
   input logic           clock,
   input logic           reset,
   sssa_req_if.sink      req_ch,
   sssa_rsp_if.source    rsp_ch
);

   // Slot and count widths follow the capacity. XW is wide enough to compare any
   // counter with any request index and to feed the fixed-width response fields.
   localparam int SW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > sssa_pkg::COUNT_W) ? CW : sssa_pkg::COUNT_W;

   // Sequencer states.
   localparam logic [1:0] ST_IDLE = 2'd0;  // waiting for a request transfer
   localparam logic [1:0] ST_READ = 2'd1;  // first memory reads are back
   localparam logic [1:0] ST_LINK = 2'd2;  // dense entry at the slot's position is back

   logic [1:0]          state_ff, state_in;
   sssa_pkg::mode_type  mode_ff, mode_in;
   sssa_pkg::index_type idx_ff, idx_in;
   logic [CW-1:0]       live_ff, live_in;
   logic [CW-1:0]       freed_ff, freed_in;
   logic [CW-1:0]       fresh_ff, fresh_in;
   logic                pre_ok_ff, pre_ok_in;
   logic [SW-1:0]       hole_ff, hole_in;
   logic [SW-1:0]       last_ff, last_in;

   logic                  rsp_valid_ff;
   sssa_pkg::slot_type    rsp_slot_ff;
   sssa_pkg::status_type  rsp_status_ff;
   sssa_pkg::count_type   rsp_count_ff;

   // Memory ports.
   logic          pos_we, pos_re, sap_we, sap_re, free_we, free_re;
   logic [SW-1:0] pos_waddr, pos_wdata, pos_raddr, pos_rdata;
   logic [SW-1:0] sap_waddr, sap_wdata, sap_raddr, sap_rdata;
   logic [SW-1:0] free_waddr, free_wdata, free_raddr, free_rdata;

   // Result of the operation finishing in this cycle.
   logic                 res_load;
   logic [SW-1:0]        res_slot;
   sssa_pkg::status_type res_status;
   logic [XW-1:0]        res_slot_x, live_in_x;

   logic          accept, out_free, pop, got, add_ok, link_live;
   logic [XW-1:0] req_idx_x, idx_x, live_x, fresh_x, freed_x, cap_x, pos_x;
   logic [CW-1:0] live_dec, freed_dec;
   logic [SW-1:0] new_slot, idx_slot;

   // A successful remove finishing in this cycle, and any memory write in this cycle.
   logic          remove_commit, any_write;

   sssa_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_pos_ram (
      .clock  (clock),
      .wr_en  (pos_we),
      .wr_addr(pos_waddr),
      .wr_data(pos_wdata),
      .rd_en  (pos_re),
      .rd_addr(pos_raddr),
      .rd_data(pos_rdata)
   );

   sssa_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_sap_ram (
      .clock  (clock),
      .wr_en  (sap_we),
      .wr_addr(sap_waddr),
      .wr_data(sap_wdata),
      .rd_en  (sap_re),
      .rd_addr(sap_raddr),
      .rd_data(sap_rdata)
   );

   sssa_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_free_ram (
      .clock  (clock),
      .wr_en  (free_we),
      .wr_addr(free_waddr),
      .wr_data(free_wdata),
      .rd_en  (free_re),
      .rd_addr(free_raddr),
      .rd_data(free_rdata)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   // The response register can take a new result when it is empty or being drained.
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   assign req_idx_x = XW'(req_ch.index);
   assign idx_x     = XW'(idx_ff);
   assign idx_slot  = idx_x[SW-1:0];
   assign live_x    = XW'(live_ff);
   assign fresh_x   = XW'(fresh_ff);
   assign freed_x   = XW'(freed_ff);
   assign cap_x     = XW'(CAPACITY);
   assign pos_x     = XW'(pos_rdata);
   assign live_dec  = live_ff - CW'(1);
   assign freed_dec = freed_ff - CW'(1);

   // Add: pop the free stack first, else take the next never-used slot.
   assign pop      = (freed_ff != '0) && (freed_x <= cap_x);
   assign got      = pop || (fresh_x < cap_x);
   assign new_slot = pop ? free_rdata : fresh_ff[SW-1:0];
   assign add_ok   = got && (live_x < cap_x);

   // A slot is live when its recorded position lies inside the dense list and the dense
   // entry there points back at it. Slots at or above fresh_ff were never written and
   // are rejected before their position is used.
   assign link_live = pre_ok_ff && (sap_rdata == idx_slot);

   always_comb begin
      state_in   = state_ff;
      mode_in    = mode_ff;
      idx_in     = idx_ff;
      live_in    = live_ff;
      freed_in   = freed_ff;
      fresh_in   = fresh_ff;
      pre_ok_in  = pre_ok_ff;
      hole_in    = hole_ff;
      last_in    = last_ff;
      pos_we     = 1'b0;
      pos_waddr  = new_slot;
      pos_wdata  = live_ff[SW-1:0];
      pos_re     = 1'b0;
      pos_raddr  = req_idx_x[SW-1:0];
      sap_we     = 1'b0;
      sap_waddr  = live_ff[SW-1:0];
      sap_wdata  = new_slot;
      sap_re     = 1'b0;
      sap_raddr  = live_dec[SW-1:0];
      free_we    = 1'b0;
      free_waddr = freed_ff[SW-1:0];
      free_wdata = idx_slot;
      free_re    = 1'b0;
      free_raddr = freed_dec[SW-1:0];
      res_load   = 1'b0;
      res_slot   = '0;
      res_status = sssa_pkg::STATUS_OK;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in  = req_ch.mode;
               idx_in   = req_ch.index;
               // Launch every read the operation may need at once: the slot's position,
               // the dense entry (requested position for get, last entry otherwise) and
               // the top of the free stack.
               pos_re   = 1'b1;
               sap_re   = 1'b1;
               free_re  = 1'b1;
               if (req_ch.mode == sssa_pkg::MODE_GET) begin
                  sap_raddr = req_idx_x[SW-1:0];
               end
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            unique case (mode_ff)
               sssa_pkg::MODE_ADD: begin
                  if (out_free) begin
                     if (pop) begin
                        freed_in = freed_dec;
                     end else if (got) begin
                        fresh_in = fresh_ff + CW'(1);
                     end
                     if (add_ok) begin
                        pos_we   = 1'b1;
                        sap_we   = 1'b1;
                        live_in  = live_ff + CW'(1);
                        res_slot = new_slot;
                     end else begin
                        res_status = sssa_pkg::STATUS_FULL;
                     end
                     res_load = 1'b1;
                     state_in = ST_IDLE;
                  end
               end
               sssa_pkg::MODE_GET: begin
                  if (out_free) begin
                     if (idx_x < live_x) begin
                        res_slot = sap_rdata;
                     end else begin
                        res_status = sssa_pkg::STATUS_NOT_LIVE;
                     end
                     res_load = 1'b1;
                     state_in = ST_IDLE;
                  end
               end
               sssa_pkg::MODE_REMOVE, sssa_pkg::MODE_CHECK: begin
                  // Keep the position and the last dense entry, then read the dense
                  // entry at that position to close the membership test.
                  pre_ok_in = (idx_x < fresh_x) && (pos_x < live_x);
                  hole_in   = pos_rdata;
                  last_in   = sap_rdata;
                  sap_re    = 1'b1;
                  sap_raddr = pos_rdata;
                  state_in  = ST_LINK;
               end
            endcase
         end
         ST_LINK: begin
            if (out_free) begin
               if (link_live) begin
                  res_slot = idx_slot;
                  if (mode_ff == sssa_pkg::MODE_REMOVE) begin
                     // Move the last dense entry into the hole and push the slot.
                     sap_we    = 1'b1;
                     sap_waddr = hole_ff;
                     sap_wdata = last_ff;
                     pos_we    = 1'b1;
                     pos_waddr = last_ff;
                     pos_wdata = hole_ff;
                     live_in   = live_dec;
                     if (freed_x < cap_x) begin
                        free_we  = 1'b1;
                        freed_in = freed_ff + CW'(1);
                     end
                  end
               end else begin
                  res_status = sssa_pkg::STATUS_NOT_LIVE;
               end
               res_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign res_slot_x = XW'(res_slot);
   assign live_in_x  = XW'(live_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         live_ff      <= '0;
         freed_ff     <= '0;
         fresh_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         live_ff  <= live_in;
         freed_ff <= freed_in;
         fresh_ff <= fresh_in;
         if (res_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      idx_ff    <= idx_in;
      pre_ok_ff <= pre_ok_in;
      hole_ff   <= hole_in;
      last_ff   <= last_in;
      if (res_load) begin
         rsp_slot_ff   <= res_slot_x[sssa_pkg::SLOT_W-1:0];
         rsp_status_ff <= res_status;
         rsp_count_ff  <= live_in_x[sssa_pkg::COUNT_W-1:0];
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.slot       = rsp_slot_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.live_count = rsp_count_ff;

   assign remove_commit = (state_ff == ST_LINK) && out_free && link_live &&
                          (mode_ff == sssa_pkg::MODE_REMOVE);
   assign any_write     = pos_we || sap_we || free_we;

   // Every slot ever handed out is either live or on the free stack.
   `SSSA_ASSERT_NOW(a_slot_balance, clock, reset, 1'b1, (live_x + freed_x) == fresh_x)
   // The memories are only written while an operation finishes.
   `SSSA_ASSERT_NOW(a_idle_no_write, clock, reset, state_ff == ST_IDLE, !any_write)
   // A successful remove shrinks the dense list by exactly one.
   `SSSA_ASSERT_NEXT(a_remove_shrinks, clock, reset, remove_commit, (live_ff + CW'(1)) == $past(live_ff))

endmodule
